[design/lidar_point_camera_projector_unit_assert.svh]
// Assertion macros for the lidar point camera projector checker.
// No dependencies; included by the checker module, which supplies clk and rst_n.
`ifndef LIDAR_POINT_CAMERA_PROJECTOR_UNIT_ASSERT_SVH
`define LIDAR_POINT_CAMERA_PROJECTOR_UNIT_ASSERT_SVH

// Property checked every edge outside reset.
`define LPCP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Signal holds in the cycle after cond.
`define LPCP_ASSERT_HOLD(lbl, cond, sig, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) cond |=> $stable(sig)) \
    else $error(msg);

`endif

[design/lpcp_pkg.sv]
// Shared types and constants of the lidar point camera projector.
// No dependencies.
package lpcp_pkg;

  localparam int QUOT_BITS = 19;
  localparam int FRAC_BITS = 16;
  localparam int NORM_BITS = 21;
  localparam logic [QUOT_BITS:0] NORM_LIMIT = 20'd524288;
  localparam logic [12:0] MAX_DIM = 13'd4096;

  typedef enum logic [2:0] {
    REG_XFORM_ROW0    = 3'd0,
    REG_XFORM_ROW1    = 3'd1,
    REG_XFORM_ROW2    = 3'd2,
    REG_INTRINSICS    = 3'd3,
    REG_RADIAL        = 3'd4,
    REG_TANGENTIAL    = 3'd5,
    REG_IMAGE_WIDTH   = 3'd6,
    REG_IMAGE_HEIGHT  = 3'd7
  } lpcp_reg_t;

  typedef struct packed {
    logic valid;
    logic front;
    logic neg_x;
    logic neg_y;
    logic sat_x;
    logic sat_y;
  } lpcp_side_t;

endpackage

[design/lpcp_div.sv]
// Pipelined restoring divider: two Q.16 quotients over a shared positive divisor.
// Depends on lpcp_pkg.
module lpcp_div #(
  parameter int MW = 36
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  lpcp_pkg::lpcp_side_t            in_side,
  input  logic [MW-1:0]                   in_num_x,
  input  logic [MW-1:0]                   in_num_y,
  input  logic [MW-1:0]                   in_den,
  output lpcp_pkg::lpcp_side_t            out_side,
  output logic [lpcp_pkg::QUOT_BITS-1:0]  out_q_x,
  output logic [lpcp_pkg::QUOT_BITS-1:0]  out_q_y
);

  localparam int STEPS = lpcp_pkg::QUOT_BITS;
  localparam int RW    = MW + STEPS - 1;

  lpcp_pkg::lpcp_side_t side_r [STEPS];
  logic [RW-1:0]        rem_x_r [STEPS];
  logic [RW-1:0]        rem_y_r [STEPS];
  logic [MW-1:0]        den_r   [STEPS];
  logic [STEPS-1:0]     q_x_r   [STEPS];
  logic [STEPS-1:0]     q_y_r   [STEPS];

  function automatic logic [RW:0] div_step(input logic [RW-1:0] rem,
                                           input logic [RW-1:0] dsh);
    logic [RW:0] diff;
    diff = {1'b0, rem} - {1'b0, dsh};
    if (diff[RW]) begin
      return {1'b0, rem};
    end
    return {1'b1, diff[RW-1:0]};
  endfunction

  for (genvar s = 0; s < STEPS; s++) begin : g_step
    localparam int SH = STEPS - 1 - s;
    lpcp_pkg::lpcp_side_t side_in;
    logic [RW-1:0]        rx_in;
    logic [RW-1:0]        ry_in;
    logic [MW-1:0]        d_in;
    logic [STEPS-1:0]     qx_in;
    logic [STEPS-1:0]     qy_in;
    logic [RW-1:0]        dsh;
    logic [RW:0]          sx;
    logic [RW:0]          sy;

    if (s == 0) begin : g_head
      assign side_in = in_side;
      assign rx_in   = RW'(in_num_x) << lpcp_pkg::FRAC_BITS;
      assign ry_in   = RW'(in_num_y) << lpcp_pkg::FRAC_BITS;
      assign d_in    = in_den;
      assign qx_in   = '0;
      assign qy_in   = '0;
    end else begin : g_body
      assign side_in = side_r[s-1];
      assign rx_in   = rem_x_r[s-1];
      assign ry_in   = rem_y_r[s-1];
      assign d_in    = den_r[s-1];
      assign qx_in   = q_x_r[s-1];
      assign qy_in   = q_y_r[s-1];
    end

    assign dsh = RW'(d_in) << SH;
    assign sx  = div_step(rx_in, dsh);
    assign sy  = div_step(ry_in, dsh);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        side_r[s] <= '0;
      end else if (en) begin
        side_r[s] <= side_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_x_r[s] <= sx[RW-1:0];
        rem_y_r[s] <= sy[RW-1:0];
        den_r[s]   <= d_in;
        q_x_r[s]   <= {qx_in[STEPS-2:0], sx[RW]};
        q_y_r[s]   <= {qy_in[STEPS-2:0], sy[RW]};
      end
    end
  end

  assign out_side = side_r[STEPS-1];
  assign out_q_x  = q_x_r[STEPS-1];
  assign out_q_y  = q_y_r[STEPS-1];

endmodule

[design/lidar_point_camera_projector_unit.sv]
// Lidar point to camera pixel projector: transform, divide, distort, scale, bound check.
// Depends on lpcp_pkg and lpcp_div.
//
//  channel | ports                       | contents
//  input   | in_tvalid/in_tready/in_tdata | one lidar point per transaction
//  output  | out_tvalid/out_tready/...    | pixel, in_front, visible
//  config  | cfg_wr_en/cfg_index/cfg_wdata| register write, no read-back
//
// One point per cycle while the output is not stalled; the divider pipeline is part of the path.
// rst_n is synchronous; it clears valid bits and loads the configuration defaults.
// A stalled output freezes the whole pipeline; nothing is lost or repeated.
module lidar_point_camera_projector_unit #(
  parameter int COORD_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // point_x, point_y, point_z
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // pixel_u, pixel_v
  output logic [1:0]  out_tuser,  // in_front, visible
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);

  localparam int CB = COORD_BITS;
  localparam int PW = CB + 16;
  localparam int CW = ((CB + 3 > 25) ? CB + 3 : 25) + 1;
  localparam int NB = lpcp_pkg::NORM_BITS;

  // configuration
  logic [63:0] xf_r [3];
  logic [63:0] intr_r;
  logic [47:0] radc_r;
  logic [31:0] tanc_r;
  logic [12:0] width_r;
  logic [12:0] height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xf_r[0]  <= 64'd16384;
      xf_r[1]  <= 64'd1073741824;
      xf_r[2]  <= 64'd70368744177664;
      intr_r   <= '0;
      radc_r   <= '0;
      tanc_r   <= '0;
      width_r  <= 13'd1280;
      height_r <= 13'd720;
    end else if (cfg_wr_en) begin
      case (lpcp_pkg::lpcp_reg_t'(cfg_index))
        lpcp_pkg::REG_XFORM_ROW0:   xf_r[0]  <= cfg_wdata;
        lpcp_pkg::REG_XFORM_ROW1:   xf_r[1]  <= cfg_wdata;
        lpcp_pkg::REG_XFORM_ROW2:   xf_r[2]  <= cfg_wdata;
        lpcp_pkg::REG_INTRINSICS:   intr_r   <= cfg_wdata;
        lpcp_pkg::REG_RADIAL:       radc_r   <= cfg_wdata[47:0];
        lpcp_pkg::REG_TANGENTIAL:   tanc_r   <= cfg_wdata[31:0];
        lpcp_pkg::REG_IMAGE_WIDTH:  width_r  <= cfg_wdata[12:0];
        lpcp_pkg::REG_IMAGE_HEIGHT: height_r <= cfg_wdata[12:0];
        default: ;
      endcase
    end
  end

  logic adv;
  logic out_valid_r;

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;

  // stage 1: rotation products
  logic signed [CB-1:0] p_in [3];
  logic signed [PW-1:0] prod_nxt [3][3];
  logic signed [PW-1:0] prod_r   [3][3];
  logic                 v1_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      p_in[k] = $signed(CB'(64'(in_tdata[32*k +: 32])));
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod_nxt[i][j] = $signed(xf_r[i][16*j +: 16]) * p_in[j];
      end
    end
  end

  // stage 2: camera coordinates
  logic signed [CW-1:0] cam_nxt [3];
  logic signed [CW-1:0] cam_r   [3];
  logic                 v2_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cam_nxt[i] = CW'(prod_r[i][0] >>> 14) + CW'(prod_r[i][1] >>> 14)
                 + CW'(prod_r[i][2] >>> 14)
                 + (CW'($signed(xf_r[i][63:48])) <<< 9);
    end
  end

  // stage 3: magnitudes, saturation test, divisor
  lpcp_pkg::lpcp_side_t side_nxt;
  lpcp_pkg::lpcp_side_t side3_r;
  logic [CW-1:0]        mag_x_nxt, mag_y_nxt;
  logic [CW-1:0]        mag_x_r, mag_y_r, den_r;

  always_comb begin
    mag_x_nxt      = cam_r[0][CW-1] ? CW'(-cam_r[0]) : cam_r[0];
    mag_y_nxt      = cam_r[1][CW-1] ? CW'(-cam_r[1]) : cam_r[1];
    side_nxt.valid = v2_r;
    side_nxt.front = !cam_r[2][CW-1] && (cam_r[2] != '0);
    side_nxt.neg_x = cam_r[0][CW-1];
    side_nxt.neg_y = cam_r[1][CW-1];
    side_nxt.sat_x = {3'b000, mag_x_nxt} >= {cam_r[2], 3'b000};
    side_nxt.sat_y = {3'b000, mag_y_nxt} >= {cam_r[2], 3'b000};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      side3_r <= '0;
    end else if (adv) begin
      v1_r    <= in_tvalid;
      v2_r    <= v1_r;
      side3_r <= side_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r  <= prod_nxt;
      cam_r   <= cam_nxt;
      mag_x_r <= mag_x_nxt;
      mag_y_r <= mag_y_nxt;
      den_r   <= cam_r[2];
    end
  end

  lpcp_pkg::lpcp_side_t            div_side;
  logic [lpcp_pkg::QUOT_BITS-1:0]  q_x, q_y;

  lpcp_div #(.MW(CW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_side  (side3_r),
    .in_num_x (mag_x_r),
    .in_num_y (mag_y_r),
    .in_den   (den_r),
    .out_side (div_side),
    .out_q_x  (q_x),
    .out_q_y  (q_y)
  );

  // valid and in-front bits for stages 4..13
  logic [13:4] vld_r;
  logic [13:4] frt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[12:4], div_side.valid};
    end
  end

  // stage 4: signed normalized coordinates
  logic [lpcp_pkg::QUOT_BITS:0] qm_x, qm_y;
  logic signed [NB-1:0]         a_nxt, b_nxt;
  logic signed [NB-1:0]         a4_r, b4_r, a5_r, b5_r, a6_r, b6_r, a7_r, b7_r;
  logic signed [NB-1:0]         a8_r, b8_r, a9_r, b9_r, a10_r, b10_r;

  always_comb begin
    qm_x  = div_side.sat_x ? lpcp_pkg::NORM_LIMIT : {1'b0, q_x};
    qm_y  = div_side.sat_y ? lpcp_pkg::NORM_LIMIT : {1'b0, q_y};
    a_nxt = div_side.neg_x ? -$signed({1'b0, qm_x}) : $signed({1'b0, qm_x});
    b_nxt = div_side.neg_y ? -$signed({1'b0, qm_y}) : $signed({1'b0, qm_y});
  end

  // stages 5..10: distortion polynomial
  logic signed [41:0] aa_r, bb_r, abp_r;
  logic signed [23:0] a2_r, b2_r, ab_r;
  logic signed [24:0] r2_r, r2_7_r;
  logic signed [26:0] sx_term, sy_term;
  logic signed [49:0] r4p_r;
  logic signed [40:0] k1r2_r, k1r2_8_r, k1r2_9_r;
  logic signed [39:0] tx1_r, ty2_r;
  logic signed [42:0] tx2_r, ty1_r;
  logic signed [31:0] r4;
  logic signed [56:0] r6p_r;
  logic signed [47:0] k2r4_r, k2r4_9_r;
  logic signed [44:0] tx_r, ty_r, tx_9_r, ty_9_r;
  logic signed [40:0] r6;
  logic signed [56:0] k3r6_r;
  logic signed [58:0] rad_sum;
  logic signed [41:0] rad_r;
  logic signed [32:0] txs_r, tys_r, txs11_r, tys11_r;

  assign sx_term = 27'(r2_r) + (27'(a2_r) <<< 1);
  assign sy_term = 27'(r2_r) + (27'(b2_r) <<< 1);
  assign r4      = 32'(r4p_r >>> 16);
  assign r6      = 41'(r6p_r >>> 16);
  assign rad_sum = 59'sd536870912 + 59'(k1r2_9_r) + 59'(k2r4_9_r) + 59'(k3r6_r);

  // stages 11..13: distortion scale, focal length, centre
  logic signed [41:0] mxh_r, myh_r;
  logic signed [42:0] mxl_r, myl_r;
  logic signed [63:0] arad_x, arad_y;
  logic signed [47:0] xd, yd;
  logic signed [33:0] xs_nxt, ys_nxt, xs_r, ys_r;
  logic signed [51:0] ua_r, va_r;

  always_comb begin
    arad_x = (64'(mxh_r) <<< 21) + 64'(mxl_r);
    arad_y = (64'(myh_r) <<< 21) + 64'(myl_r);
    xd     = 48'(arad_x >>> 16) + 48'(txs11_r);
    yd     = 48'(arad_y >>> 16) + 48'(tys11_r);
    if (xd[47:33] == '0 || xd[47:33] == '1) begin
      xs_nxt = xd[33:0];
    end else begin
      xs_nxt = xd[47] ? {1'b1, 33'd0} : {1'b0, {33{1'b1}}};
    end
    if (yd[47:33] == '0 || yd[47:33] == '1) begin
      ys_nxt = yd[33:0];
    end else begin
      ys_nxt = yd[47] ? {1'b1, 33'd0} : {1'b0, {33{1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      frt_r    <= {frt_r[12:4], div_side.front};
      a4_r     <= a_nxt;
      b4_r     <= b_nxt;
      aa_r     <= a4_r * a4_r;
      bb_r     <= b4_r * b4_r;
      abp_r    <= a4_r * b4_r;
      a5_r     <= a4_r;
      b5_r     <= b4_r;
      a2_r     <= 24'(aa_r >>> 16);
      b2_r     <= 24'(bb_r >>> 16);
      ab_r     <= 24'(abp_r >>> 16);
      r2_r     <= 25'((aa_r + bb_r) >>> 16);
      a6_r     <= a5_r;
      b6_r     <= b5_r;
      r4p_r    <= r2_r * r2_r;
      k1r2_r   <= $signed(radc_r[15:0]) * r2_r;
      tx1_r    <= $signed(tanc_r[15:0]) * ab_r;
      tx2_r    <= $signed(tanc_r[31:16]) * sx_term;
      ty1_r    <= $signed(tanc_r[15:0]) * sy_term;
      ty2_r    <= $signed(tanc_r[31:16]) * ab_r;
      r2_7_r   <= r2_r;
      a7_r     <= a6_r;
      b7_r     <= b6_r;
      r6p_r    <= r4 * r2_7_r;
      k2r4_r   <= $signed(radc_r[31:16]) * r4;
      k1r2_8_r <= k1r2_r;
      tx_r     <= (45'(tx1_r) <<< 1) + 45'(tx2_r);
      ty_r     <= 45'(ty1_r) + (45'(ty2_r) <<< 1);
      a8_r     <= a7_r;
      b8_r     <= b7_r;
      k3r6_r   <= $signed(radc_r[47:32]) * r6;
      k1r2_9_r <= k1r2_8_r;
      k2r4_9_r <= k2r4_r;
      tx_9_r   <= tx_r;
      ty_9_r   <= ty_r;
      a9_r     <= a8_r;
      b9_r     <= b8_r;
      rad_r    <= 42'(rad_sum >>> 13);
      txs_r    <= 33'(tx_9_r >>> 13);
      tys_r    <= 33'(ty_9_r >>> 13);
      a10_r    <= a9_r;
      b10_r    <= b9_r;
      mxh_r    <= a10_r * $signed(rad_r[41:21]);
      mxl_r    <= a10_r * $signed({1'b0, rad_r[20:0]});
      myh_r    <= b10_r * $signed(rad_r[41:21]);
      myl_r    <= b10_r * $signed({1'b0, rad_r[20:0]});
      txs11_r  <= txs_r;
      tys11_r  <= tys_r;
      xs_r     <= xs_nxt;
      ys_r     <= ys_nxt;
      ua_r     <= $signed({1'b0, intr_r[15:0]}) * xs_r
                + $signed({4'd0, intr_r[47:32], 16'd0});
      va_r     <= $signed({1'b0, intr_r[31:16]}) * ys_r
                + $signed({4'd0, intr_r[63:48], 16'd0});
    end
  end

  // stage 14: bounds and output register
  logic [12:0] w_lim, h_lim;
  logic        u_ok, v_ok, vis_nxt;
  logic [11:0] pu_nxt, pv_nxt;
  logic [11:0] pu_r, pv_r;
  logic        vis_r, front_r;

  always_comb begin
    w_lim   = (width_r > lpcp_pkg::MAX_DIM) ? lpcp_pkg::MAX_DIM : width_r;
    h_lim   = (height_r > lpcp_pkg::MAX_DIM) ? lpcp_pkg::MAX_DIM : height_r;
    u_ok    = (!ua_r[51] && (ua_r[50:20] < 31'(w_lim)))
           || (ua_r[51] && (&ua_r[51:20]) && (|ua_r[19:0]) && (w_lim != '0));
    v_ok    = (!va_r[51] && (va_r[50:20] < 31'(h_lim)))
           || (va_r[51] && (&va_r[51:20]) && (|va_r[19:0]) && (h_lim != '0));
    vis_nxt = frt_r[13] && u_ok && v_ok;
    pu_nxt  = (vis_nxt && !ua_r[51]) ? ua_r[31:20] : '0;
    pv_nxt  = (vis_nxt && !va_r[51]) ? va_r[31:20] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vld_r[13];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pu_r    <= pu_nxt;
      pv_r    <= pv_nxt;
      vis_r   <= vis_nxt;
      front_r <= frt_r[13];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {pv_r, pu_r};
  assign out_tuser  = {vis_r, front_r};

endmodule

[design/lpcp_checker.sv]
// Port-level checker for the lidar point camera projector, bound to the top level.
// Depends on lidar_point_camera_projector_unit_assert.svh.
`include "lidar_point_camera_projector_unit_assert.svh"

module lpcp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic [1:0]  out_tuser
);

  `LPCP_ASSERT(a_vis_front, (out_tvalid && out_tuser[1]) |-> out_tuser[0], "visible behind camera")
  `LPCP_ASSERT(a_hid_zero, (out_tvalid && !out_tuser[1]) |-> out_tdata == '0, "pixel not zero")
  `LPCP_ASSERT(a_ready_free, (!out_tvalid || out_tready) |-> in_tready, "stall with free output")
  `LPCP_ASSERT_HOLD(a_out_hold, out_tvalid && !out_tready, out_tdata, "stalled data changed")

endmodule

bind lidar_point_camera_projector_unit lpcp_checker u_lpcp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
